// ===== rtl/whole_word_occurrence_counter_top_defines.svh =====
// Assertion macros for the whole-word occurrence counter.
`ifndef WHOLE_WORD_OCCURRENCE_COUNTER_TOP_DEFINES_SVH
`define WHOLE_WORD_OCCURRENCE_COUNTER_TOP_DEFINES_SVH

// Checked only while out of reset.
`define WWOC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define WWOC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/wwoc_pkg.sv =====
// Package: shared constants, types and helpers of the whole-word occurrence counter.
`timescale 1ns / 1ps
package wwoc_pkg;
	localparam int MAX_WORD = 16;
	localparam int LEN_W    = $clog2(MAX_WORD + 1);
	localparam int IDX_W    = $clog2(MAX_WORD);
	localparam int CNT_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;

	localparam logic [7:0] BYTE_NL = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;

	typedef struct packed {
		logic [MAX_WORD-1:0][7:0] bytes;
		logic [LEN_W-1:0]         len;
	} needle_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       eos;
	} step_t;

	typedef struct packed {
		logic             match;
		logic [LEN_W-1:0] since_match;
	} win_status_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
	endfunction
endpackage

// ===== rtl/wwoc_cfg.sv =====
// Configuration registers: needle bytes and needle length.
`timescale 1ns / 1ps
module wwoc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [wwoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wwoc_pkg::CFG_DAT_W-1:0]  cfg_data,
	output wwoc_pkg::needle_t               needle
);
	import wwoc_pkg::*;

	logic [CFG_DAT_W-1:0] low_q;
	logic [CFG_DAT_W-1:0] high_q;
	logic [LEN_W-1:0]     len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			len_q  <= LEN_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NEEDLE_LOW:  low_q  <= cfg_data;
				REG_NEEDLE_HIGH: high_q <= cfg_data;
				REG_NEEDLE_LEN:  len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign needle.bytes = {high_q, low_q};
	assign needle.len   = len_q;
endmodule

// ===== rtl/wwoc_window.sv =====
// Line window: recent bytes, run counters and the parallel word compare.
`timescale 1ns / 1ps
module wwoc_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wwoc_pkg::step_t       step,
	input  wwoc_pkg::needle_t     needle,
	output wwoc_pkg::win_status_t status
);
	import wwoc_pkg::*;

	logic [MAX_WORD-1:0][7:0] recent_q;
	logic [LEN_W-1:0]         run_q;
	logic [LEN_W-1:0]         since_q;

	logic [MAX_WORD-1:0][7:0] recent_n;
	logic [LEN_W-1:0]         run_inc;
	logic [LEN_W-1:0]         since_inc;
	logic [LEN_W-1:0]         len_m1;
	logic [LEN_W-1:0]         pos;
	logic                     is_nl;
	logic                     len_ok;
	logic                     eq;
	logic                     match;

	assign is_nl     = (step.data == BYTE_NL);
	assign recent_n  = {recent_q[MAX_WORD-2:0], step.data};
	assign run_inc   = (run_q == LEN_W'(MAX_WORD)) ? run_q : run_q + LEN_W'(1);
	assign since_inc = (since_q == LEN_W'(MAX_WORD)) ? since_q : since_q + LEN_W'(1);
	assign len_ok    = (needle.len != '0) && (needle.len <= LEN_W'(MAX_WORD));
	assign len_m1    = needle.len - LEN_W'(1);

	// window slot j holds word byte len-1-j
	always_comb begin
		eq  = 1'b1;
		pos = '0;
		for (int j = 0; j < MAX_WORD; j++) begin
			pos = len_m1 - LEN_W'(j);
			if (LEN_W'(j) < needle.len) begin
				if (recent_n[j] != needle.bytes[pos[IDX_W-1:0]])
					eq = 1'b0;
			end
		end
	end

	assign match = !is_nl && len_ok && eq
		&& (run_inc >= needle.len) && (since_inc >= needle.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			run_q    <= '0;
			since_q  <= LEN_W'(MAX_WORD);
		end else if (step.valid) begin
			if (!is_nl)
				recent_q <= recent_n;
			if (is_nl || step.eos)
				run_q <= '0;
			else
				run_q <= run_inc;
			if (step.eos)
				since_q <= LEN_W'(MAX_WORD);
			else if (match)
				since_q <= '0;
			else if (!is_nl)
				since_q <= since_inc;
		end
	end

	assign status.match       = match;
	assign status.since_match = since_q;
endmodule

// ===== rtl/whole_word_occurrence_counter_top.sv =====
// Top level: whole-word occurrence counter with input and result registers.
`timescale 1ns / 1ps
// Counts leftmost, non-overlapping whole-word matches of a 1 to 16 byte word in a byte
// stream, one byte per cycle while results are taken. Each accepted byte is held in an
// input register. Once the result register can advance, the byte is compared against the
// 16-byte line window in parallel and the result register is loaded. A stalled result
// blocks the input only when both registers are full. A match is settled by the byte
// after it (a non-letter counts it) or at once on end_of_stream. The user writes the
// needle registers through the cfg port only while the block is idle; the block itself
// does not enforce it.
module whole_word_occurrence_counter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_stream,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wwoc_pkg::CNT_W-1:0]      occurrence_count,
	output logic                            counted_now,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wwoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wwoc_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import wwoc_pkg::*;
	`include "whole_word_occurrence_counter_top_defines.svh"

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        pending_q;
	logic [CNT_W-1:0] tally_q;
	logic        counted_q;
	logic        out_valid_q;

	logic        adv;
	logic        fire;
	logic        hit_pending;
	logic        hit_eos;
	logic [1:0]  hits;
	step_t       step;
	needle_t     needle;
	win_status_t win;

	assign cfg_ready = 1'b1;

	wwoc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.needle   (needle)
	);

	assign adv      = !out_valid_q || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	assign step.valid = fire;
	assign step.data  = byte_s1;
	assign step.eos   = eos_s1;

	wwoc_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.needle(needle),
		.status(win)
	);

	assign hit_pending = pending_q && !is_letter(byte_s1);
	assign hit_eos     = win.match && eos_s1;
	assign hits        = {1'b0, hit_pending} + {1'b0, hit_eos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			eos_s1  <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pending_q <= win.match && !eos_s1;
				tally_q   <= tally_q + CNT_W'(hits);
			end
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			counted_q <= (hits != 2'd0);
	end

	assign out_valid        = out_valid_q;
	assign occurrence_count = tally_q;
	assign counted_now      = counted_q;

	`WWOC_ASSERT(a_pending_after_match, pending_q |-> (win.since_match == '0), "stale pending")
	`WWOC_ASSERT(a_eos_clears, (fire && eos_s1) |=> (!pending_q && (win.since_match == LEN_W'(MAX_WORD))), "eos left state")
	`WWOC_ASSERT(a_hit_reported, (fire && (hits != 2'd0)) |=> (out_valid && counted_now), "hit lost")
	`WWOC_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (!out_valid && !pending_q), "active in reset")
endmodule

// ===== verif/tb_whole_word_occurrence_counter_top.sv =====
// Testbench: checks the whole-word occurrence counter against a built-in count predictor.
`timescale 1ns / 1ps
module tb_whole_word_occurrence_counter_top;
	import wwoc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	class occurrence_scoreboard;
		typedef struct {
			logic [CNT_W-1:0] count;
			logic             hit;
		} count_word_t;

		logic [CFG_DAT_W-1:0] needle_lo;
		logic [CFG_DAT_W-1:0] needle_hi;
		logic [LEN_W-1:0]     needle_len;
		logic [7:0]           line_tail [MAX_WORD];
		int unsigned          line_run;
		int unsigned          since_match;
		bit                   pending;
		logic [CNT_W-1:0]     tally;
		count_word_t          expected_counts [$];
		int                   errors;

		function new();
			needle_lo = '0;
			needle_hi = '0;
			needle_len = LEN_W'(1);
			foreach (line_tail[i]) line_tail[i] = 8'h00;
			line_run = 0;
			since_match = MAX_WORD;
			pending = 0;
			tally = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_NEEDLE_LOW: begin
					needle_lo = val;
				end
				REG_NEEDLE_HIGH: begin
					needle_hi = val;
				end
				REG_NEEDLE_LEN: begin
					needle_len = val[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function bit alpha(logic [7:0] b);
			logic [7:0] folded;
			folded = b | 8'h20;
			return (folded >= 8'h61) && (folded <= 8'h7a);
		endfunction

		function bit word_at_tail();
			logic [127:0] word;
			int unsigned  n;
			word = {needle_hi, needle_lo};
			n = needle_len;
			if (n == 0 || n > MAX_WORD) return 0;
			if (line_run < n || since_match < n) return 0;
			for (int i = 0; i < n; i++)
				if (line_tail[n - 1 - i] != word[8*i +: 8]) return 0;
			return 1;
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			int hits;
			hits = 0;
			if (pending) begin
				pending = 0;
				if (!alpha(b)) hits++;
			end
			if (b == BYTE_NL) begin
				line_run = 0;
			end else begin
				for (int i = MAX_WORD - 1; i > 0; i--) line_tail[i] = line_tail[i-1];
				line_tail[0] = b;
				if (line_run < MAX_WORD) line_run++;
				if (since_match < MAX_WORD) since_match++;
				if (word_at_tail()) begin
					since_match = 0;
					if (eos) hits++;
					else pending = 1;
				end
			end
			if (eos) begin
				line_run = 0;
				since_match = MAX_WORD;
				pending = 0;
			end
			tally = tally + hits;
			expected_counts.push_back('{tally, hits != 0});
		endfunction

		function void check_result(logic [CNT_W-1:0] count, logic hit);
			count_word_t exp_w;
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result, expected none, got count %0d hit %0b",
					$time, count, hit);
				errors++;
				return;
			end
			exp_w = expected_counts.pop_front();
			if (count !== exp_w.count) begin
				$display("%0t: occurrence_count expected %0d, got %0d", $time, exp_w.count, count);
				errors++;
			end
			if (hit !== exp_w.hit) begin
				$display("%0t: counted_now expected %0b, got %0b", $time, exp_w.hit, hit);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_counts.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           text_byte = 8'h00;
	logic                 end_of_stream = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CNT_W-1:0]     occurrence_count;
	logic                 counted_now;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	occurrence_scoreboard sb = new();
	bit tx_calm = 0;
	bit rx_calm = 0;
	int rx_hold = 0;
	int cycles = 0;

	whole_word_occurrence_counter_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.text_byte        (text_byte),
		.end_of_stream    (end_of_stream),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.occurrence_count (occurrence_count),
		.counted_now      (counted_now),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(occurrence_count, counted_now);
		if (rx_hold > 0) rx_hold--;
		else if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold = idle_len();
		out_ready <= (rx_hold == 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		gap = (tx_calm || $urandom_range(0, 9) < 6) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b, eos);
	endtask

	task automatic send_text(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], eos_last && (i == s.len() - 1));
	endtask

	// wait until every byte sent has been answered and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [LEN_W-1:0] len);
		cfg_beat(REG_NEEDLE_LOW, lo);
		cfg_beat(REG_NEEDLE_HIGH, hi);
		cfg_beat(REG_NEEDLE_LEN, {{(CFG_DAT_W-LEN_W){1'b0}}, len});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [127:0] random_word();
		logic [127:0] w;
		logic [7:0]   b;
		for (int i = 0; i < MAX_WORD; i++) begin
			if ($urandom_range(0, 9) < 7) b = $urandom_range(0, 1) ? 8'h61 : 8'h62;
			else b = 8'($urandom_range(0, 255));
			if (b == BYTE_NL) b = 8'h0b;
			w[8*i +: 8] = b;
		end
		return w;
	endfunction

	function automatic logic [7:0] noise_byte(input logic [127:0] w, input int wl);
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return w[8*$urandom_range(0, wl - 1) +: 8];
		if (r < 42) return 8'h61 + 8'($urandom_range(0, 25));
		if (r < 55) return 8'h41 + 8'($urandom_range(0, 25));
		if (r < 62) return 8'h20;
		if (r < 68) return 8'h2c;
		if (r < 78) return BYTE_NL;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_text(input int n_bytes);
		logic [127:0] w;
		logic [7:0]   b;
		int           wl;
		int           k;
		int           r;
		int           sent;
		w = {sb.needle_hi, sb.needle_lo};
		wl = (sb.needle_len == 0 || sb.needle_len > MAX_WORD) ?
			$urandom_range(1, MAX_WORD) : sb.needle_len;
		sent = 0;
		while (sent < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				k = (r < 35) ? wl : $urandom_range(1, wl);
				for (int i = 0; i < k; i++) begin
					b = w[8*i +: 8];
					if ($urandom_range(0, 19) == 0) b = noise_byte(w, wl);
					send_byte(b, $urandom_range(0, 199) == 0);
					sent++;
				end
			end else begin
				send_byte(noise_byte(w, wl), $urandom_range(0, 59) == 0);
				sent++;
			end
			if ($urandom_range(0, 299) == 0) drain();
		end
	endtask

	initial begin
		logic [63:0]      lo;
		logic [63:0]      hi;
		logic [LEN_W-1:0] len;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: one NUL byte as the word
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h00, 1'b1);
		drain();

		configure(64'h6261, 64'h0, 5'd2);
		send_text("abXab\na\nbab", 1'b1);
		drain();

		// settle the pending match and count a new one on the same end-of-stream byte
		configure(64'h37, 64'hffff_ffff_ffff_ffff, 5'd1);
		send_text("77", 1'b1);
		drain();

		for (int p = 0; p < 12; p++) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			{hi, lo} = random_word();
			case (p)
				0: begin
					lo = '1;
					hi = '1;
					len = 5'd16;
				end
				1: begin
					lo = '0;
					hi = '0;
					len = 5'd3;
				end
				2: len = 5'd0;
				3: len = 5'd17;
				4: len = 5'd31;
				5: begin
					lo[15:8] = BYTE_NL;
					len = 5'd4;
				end
				6: len = 5'd16;
				default: len = ($urandom_range(0, 3) == 0) ?
					LEN_W'($urandom_range(5, 16)) : LEN_W'($urandom_range(1, 4));
			endcase
			configure(lo, hi, len);
			random_text(100);
			drain();
		end

		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/wwoc_pkg.sv
rtl/wwoc_cfg.sv
rtl/wwoc_window.sv
rtl/whole_word_occurrence_counter_top.sv
verif/tb_whole_word_occurrence_counter_top.sv
